@@ design/stable_priority_queue_macros.svh @@
// assertion macros used by the stable priority queue datapath
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define SPQ_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spq assertion failed");
// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spq assertion failed");
`else
`define SPQ_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ design/spq_pkg.sv @@
// package for the stable priority queue: payload types, codes and control structs
package spq_pkg;

    // default number of slots
    localparam int CAPACITY_DEFAULT = 16;

    // command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SERVE  = 2'd1,
        CMD_PEEK   = 2'd2
    } cmd_e_t;

    // input request payload
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  priority_req;
        logic [15:0] entry_id;
    } in_t;

    // result payload
    typedef struct packed {
        logic        ok;
        logic [7:0]  out_priority;
        logic [15:0] out_entry_id;
        logic [4:0]  count;
        logic        is_empty;
    } out_t;

    // controller to datapath commands
    typedef struct packed {
        logic insert;
        logic remove;
        logic load;
        logic ok;
        logic head;
    } ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
    } stat_t;

endpackage

@@ design/stable_priority_queue.sv @@
// Stable bounded priority queue, top level.
// Input channel s_valid/s_ready/s_data carries one request: command (insert, serve,
// peek), the priority and the identifier of an entry to insert. Result channel
// m_valid/m_ready/m_data returns one result per request: ok, head priority and
// identifier for serve and peek, the count held after the request and an empty flag.
// Entries are kept sorted in a row of CAPACITY slot registers, highest priority at
// slot 0; an insert compares all slots in parallel and shifts the tail down by one,
// a serve shifts all slots up by one. Equal priorities keep their arrival order.
// A result shows in the cycle after its request. A request is taken in every cycle
// where no result waits or the waiting result is taken in that same cycle, so the
// throughput is one request per cycle, set by the single result register.
// Insert when full and serve or peek when empty are refused with ok low.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result;
// slot contents are not cleared. While the receiver holds m_ready low the result
// stays on m_data and no new request is taken.
module stable_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  spq_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output spq_pkg::out_t m_data
);

    spq_pkg::ctrl_t ctrl;
    spq_pkg::stat_t stat;

    // handshake and command decode
    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .command (s_data.command),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // sorted slots and result register
    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (s_data),
        .ctrl    (ctrl),
        .stat    (stat),
        .result  (m_data)
    );

endmodule

@@ design/spq_ctrl.sv @@
// controller for the stable priority queue: handshake state machine and command decode
module spq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [1:0]     command,
    output logic           m_valid,
    input  logic           m_ready,
    input  spq_pkg::stat_t stat,
    output spq_pkg::ctrl_t ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // take a request when no result waits or the waiting one leaves now
    assign s_ready = (state_reg == ST_IDLE) || m_ready;
    assign m_valid = (state_reg == ST_HOLD);
    assign accept  = s_valid && s_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (m_ready && !accept) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // command decode against queue status
    always_comb begin
        ctrl      = '0;
        ctrl.load = accept;
        unique case (command)
            spq_pkg::CMD_INSERT: begin
                ctrl.ok     = !stat.full;
                ctrl.insert = accept && !stat.full;
            end
            spq_pkg::CMD_SERVE: begin
                ctrl.ok     = !stat.empty;
                ctrl.head   = !stat.empty;
                ctrl.remove = accept && !stat.empty;
            end
            spq_pkg::CMD_PEEK: begin
                ctrl.ok   = !stat.empty;
                ctrl.head = !stat.empty;
            end
            default: ctrl.ok = 1'b0;
        endcase
    end

endmodule

@@ design/spq_datapath.sv @@
// datapath for the stable priority queue: sorted shift-register slots and result register
`include "stable_priority_queue_macros.svh"

module spq_datapath #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  spq_pkg::in_t   req,
    input  spq_pkg::ctrl_t ctrl,
    output spq_pkg::stat_t stat,
    output spq_pkg::out_t  result
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [7:0]    pri_reg [CAPACITY];
    logic [15:0]   id_reg  [CAPACITY];
    logic [CW-1:0] fill_reg, fill_next;
    logic [CAPACITY-1:0] keep;
    logic [CAPACITY-1:0] ins_here;
    logic [CW+4:0] count_ext;
    spq_pkg::out_t result_reg;

    // status
    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == CW'(CAPACITY));

    // per-slot compare: slot keeps its entry when it is held and not lower than the new one
    for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
        assign keep[k] = (CW'(k) < fill_reg) && (pri_reg[k] >= req.priority_req);

        if (k == 0) begin : g_head
            assign ins_here[k] = 1'b1;
        end else begin : g_body
            assign ins_here[k] = keep[k-1];
        end

        // insert shifts the tail down by one, serve shifts everything up by one
        always_ff @(posedge aclk) begin
            if (ctrl.insert) begin
                if (!keep[k]) begin
                    if (ins_here[k]) begin
                        pri_reg[k] <= req.priority_req;
                        id_reg[k]  <= req.entry_id;
                    end else begin
                        pri_reg[k] <= pri_reg[(k == 0) ? 0 : k-1];
                        id_reg[k]  <= id_reg[(k == 0) ? 0 : k-1];
                    end
                end
            end else if (ctrl.remove) begin
                pri_reg[k] <= pri_reg[(k == CAPACITY-1) ? k : k+1];
                id_reg[k]  <= id_reg[(k == CAPACITY-1) ? k : k+1];
            end
        end
    end

    // fill count
    always_comb begin
        fill_next = fill_reg;
        if (ctrl.insert) begin
            fill_next = fill_reg + CW'(1);
        end else if (ctrl.remove) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // result register, count wraps to five bits
    assign count_ext = {5'd0, fill_next};

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            result_reg.ok           <= ctrl.ok;
            result_reg.out_priority <= ctrl.head ? pri_reg[0] : 8'd0;
            result_reg.out_entry_id <= ctrl.head ? id_reg[0] : 16'd0;
            result_reg.count        <= count_ext[4:0];
            result_reg.is_empty     <= (fill_next == '0);
        end
    end

    assign result = result_reg;

    // checks
    `SPQ_ASSERT_IMPL(a_no_insert_full, aclk, aresetn, ctrl.insert, !stat.full)
    `SPQ_ASSERT_IMPL(a_no_remove_empty, aclk, aresetn, ctrl.remove, !stat.empty)
    `SPQ_ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= CW'(CAPACITY))
    `SPQ_ASSERT_NEXT(a_insert_grows, aclk, aresetn, ctrl.insert, fill_reg == $past(fill_reg) + CW'(1))
    `SPQ_ASSERT_NEXT(a_remove_shrinks, aclk, aresetn, ctrl.remove, fill_reg == $past(fill_reg) - CW'(1))

endmodule
